@@ rtl/core/ferl_pkg.sv @@
// ferl_pkg: shared constants, codes and entry type for the fault event ring logger
// no dependencies; used by the channel interfaces and the top level
`default_nettype none

package ferl_pkg;

   // ring depth and derived widths
   localparam int unsigned LOG_DEPTH = 16;
   localparam int unsigned PTR_W     = $clog2(LOG_DEPTH);
   localparam int unsigned CNT_W     = $clog2(LOG_DEPTH + 1);

   // field widths
   localparam int unsigned MODE_W  = 2;
   localparam int unsigned TICK_W  = 32;
   localparam int unsigned SEV_W   = 3;
   localparam int unsigned OSEV_W  = 2;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned KIND_W  = 2;
   localparam int unsigned POS_W   = 6;
   localparam int unsigned COUNT_W = 32;

   // operation codes
   localparam logic [MODE_W-1:0] MODE_RECORD  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_CLEAR   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_DUMP    = 2'd2;
   localparam logic [MODE_W-1:0] MODE_SUMMARY = 2'd3;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_ECHO    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ENTRY   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SUMMARY = 2'd2;
   localparam logic [KIND_W-1:0] KIND_EMPTY   = 2'd3;

   // severity codes
   localparam logic [OSEV_W-1:0] SEV_INFO  = 2'd0;
   localparam logic [OSEV_W-1:0] SEV_WARN  = 2'd1;
   localparam logic [OSEV_W-1:0] SEV_ERROR = 2'd2;

   // one stored log entry, 58 bits
   typedef struct packed {
      logic [TICK_W-1:0] tick;
      logic [OSEV_W-1:0] sev;
      logic [BYTE_W-1:0] src;
      logic [BYTE_W-1:0] det;
      logic [BYTE_W-1:0] pay;
   } log_entry_type;

endpackage

`default_nettype wire

@@ rtl/core/ferl_if.sv @@
// ferl_if: valid/ready channel interfaces for the event logger request and response
// depends on ferl_pkg for field widths
`default_nettype none

interface ferl_req_if;
   logic                         valid;
   logic                         ready;
   logic [ferl_pkg::MODE_W-1:0]  mode;
   logic [ferl_pkg::TICK_W-1:0]  tick_ms;
   logic [ferl_pkg::SEV_W-1:0]   severity;
   logic [ferl_pkg::BYTE_W-1:0]  source_id;
   logic [ferl_pkg::BYTE_W-1:0]  detail;
   logic [ferl_pkg::BYTE_W-1:0]  payload;

   modport source (output valid, mode, tick_ms, severity, source_id, detail, payload,
                   input ready);
   modport sink   (input valid, mode, tick_ms, severity, source_id, detail, payload,
                   output ready);
endinterface

interface ferl_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [ferl_pkg::KIND_W-1:0]  kind;
   logic [ferl_pkg::TICK_W-1:0]  out_tick_ms;
   logic [ferl_pkg::OSEV_W-1:0]  out_severity;
   logic [ferl_pkg::BYTE_W-1:0]  out_source;
   logic [ferl_pkg::BYTE_W-1:0]  out_detail;
   logic [ferl_pkg::BYTE_W-1:0]  out_payload;
   logic [ferl_pkg::POS_W-1:0]   position;
   logic [ferl_pkg::COUNT_W-1:0] total_count;
   logic [ferl_pkg::COUNT_W-1:0] info_count;
   logic [ferl_pkg::COUNT_W-1:0] warn_count;
   logic [ferl_pkg::COUNT_W-1:0] error_count;
   logic                         last;

   modport source (output valid, kind, out_tick_ms, out_severity, out_source, out_detail,
                   out_payload, position, total_count, info_count, warn_count,
                   error_count, last,
                   input ready);
   modport sink   (input valid, kind, out_tick_ms, out_severity, out_source, out_detail,
                   out_payload, position, total_count, info_count, warn_count,
                   error_count, last,
                   output ready);
endinterface

`default_nettype wire

@@ rtl/core/fault_event_ring_logger_unit.sv @@
// fault_event_ring_logger_unit: top level of the fault event ring logger
// depends on ferl_pkg and the channel interfaces in ferl_if.sv
//
// The logger keeps the last LOG_DEPTH fault events in a ring memory that overwrites the
// oldest entry, plus wrapping 32-bit counters for info, warning and error events and for
// all events. One item is taken at a time; all event counter increments go through one
// shared 32-bit incrementer, so a record steps through accept, severity counter, then
// total and echo. A clear takes effect on acceptance; a summary or an empty dump is sent
// from a single result state. A dump sends every entry after reading it through the
// registered read port of the ring memory. A result sits in an output register,
// so the next item is accepted while the last result still waits; a result only stalls
// the sequencer when the next one is ready and the output register is still full.
// The ring needs no clearing pass: only entries written since the last clear are read.
`default_nettype none

module fault_event_ring_logger_unit (
   input  logic        clock,
   input  logic        reset,
   ferl_req_if.sink    req_chan,
   ferl_rsp_if.source  rsp_chan
);

   localparam int unsigned LOG_DEPTH = ferl_pkg::LOG_DEPTH;
   localparam int unsigned PTR_W     = ferl_pkg::PTR_W;
   localparam int unsigned CNT_W     = ferl_pkg::CNT_W;
   localparam int unsigned POS_W     = ferl_pkg::POS_W;
   localparam int unsigned COUNT_W   = ferl_pkg::COUNT_W;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_SEV    = 6'b000010,
      S_TOT    = 6'b000100,
      S_RD     = 6'b001000,
      S_DUMP   = 6'b010000,
      S_SINGLE = 6'b100000
   } state_type;

   typedef struct packed {
      logic [ferl_pkg::KIND_W-1:0] kind;
      ferl_pkg::log_entry_type     ent;
      logic [POS_W-1:0]            pos;
      logic [COUNT_W-1:0]          total;
      logic [COUNT_W-1:0]          info;
      logic [COUNT_W-1:0]          warn;
      logic [COUNT_W-1:0]          err;
      logic                        last;
   } rsp_data_type;

   state_type                   state_ff, state_in;
   logic [ferl_pkg::MODE_W-1:0] mode_ff;
   ferl_pkg::log_entry_type     ev_ff;
   logic [PTR_W-1:0]            wp_ff;
   logic [CNT_W-1:0]            valid_cnt_ff;
   logic [PTR_W-1:0]            rd_idx_ff;
   logic [PTR_W-1:0]            pos_ff;
   logic [COUNT_W-1:0]          info_ff, warn_ff, err_ff, total_ff;
   ferl_pkg::log_entry_type     rd_data_ff;
   ferl_pkg::log_entry_type     ring_mem [LOG_DEPTH];
   logic                        rsp_valid_ff, rsp_valid_in;
   rsp_data_type                rsp_ff, rsp_in;

   logic                        accept;
   logic                        out_free;
   logic                        load_rsp;
   logic                        sev_ok;
   logic                        full;
   logic                        last_entry;
   logic [PTR_W-1:0]            wp_next;
   logic [PTR_W-1:0]            rd_next;
   logic [COUNT_W-1:0]          inc_opnd;
   logic [COUNT_W-1:0]          inc_res;
   ferl_pkg::log_entry_type     req_entry;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   // a new result goes into the output register once it is free
   assign load_rsp       = out_free && ((state_ff == S_TOT) || (state_ff == S_DUMP) ||
                                        (state_ff == S_SINGLE));
   assign rsp_valid_in   = load_rsp || (rsp_valid_ff && !rsp_chan.ready);
   // severities 4 to 7 are rejected
   assign sev_ok         = (req_chan.severity[ferl_pkg::SEV_W-1] == 1'b0);
   assign full           = (valid_cnt_ff == CNT_W'(LOG_DEPTH));
   assign wp_next        = (wp_ff == PTR_W'(LOG_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
   assign rd_next        = (rd_idx_ff == PTR_W'(LOG_DEPTH - 1)) ? '0 : rd_idx_ff + 1'b1;
   assign last_entry     = ((CNT_W'(pos_ff) + 1'b1) == valid_cnt_ff);

   assign req_entry.tick = req_chan.tick_ms;
   assign req_entry.sev  = req_chan.severity[ferl_pkg::OSEV_W-1:0];
   assign req_entry.src  = req_chan.source_id;
   assign req_entry.det  = req_chan.detail;
   assign req_entry.pay  = req_chan.payload;

   // shared incrementer: severity counter first, then the total
   always_comb begin
      inc_opnd = total_ff;
      if (state_ff == S_SEV) begin
         case (ev_ff.sev)
            ferl_pkg::SEV_INFO:  inc_opnd = info_ff;
            ferl_pkg::SEV_WARN:  inc_opnd = warn_ff;
            ferl_pkg::SEV_ERROR: inc_opnd = err_ff;
            default:             inc_opnd = total_ff;
         endcase
      end
   end

   assign inc_res = inc_opnd + COUNT_W'(1);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_chan.mode)
                  ferl_pkg::MODE_RECORD: state_in = sev_ok ? S_SEV : S_IDLE;
                  ferl_pkg::MODE_CLEAR:  state_in = S_IDLE;
                  ferl_pkg::MODE_DUMP:   state_in = (valid_cnt_ff == '0) ? S_SINGLE : S_RD;
                  default:               state_in = S_SINGLE;
               endcase
            end
         end
         S_SEV:    state_in = S_TOT;
         S_TOT:    state_in = out_free ? S_IDLE : S_TOT;
         S_RD:     state_in = S_DUMP;
         S_DUMP: begin
            if (out_free) begin
               state_in = last_entry ? S_IDLE : S_RD;
            end
         end
         S_SINGLE: state_in = out_free ? S_IDLE : S_SINGLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // result payload for the current state
   always_comb begin
      rsp_in      = '0;
      rsp_in.last = 1'b1;
      case (state_ff)
         S_TOT: begin
            rsp_in.kind = ferl_pkg::KIND_ECHO;
            rsp_in.ent  = ev_ff;
         end
         S_DUMP: begin
            rsp_in.kind = ferl_pkg::KIND_ENTRY;
            rsp_in.ent  = rd_data_ff;
            rsp_in.pos  = POS_W'(pos_ff);
            rsp_in.last = last_entry;
         end
         S_SINGLE: begin
            if (mode_ff == ferl_pkg::MODE_SUMMARY) begin
               rsp_in.kind     = ferl_pkg::KIND_SUMMARY;
               rsp_in.ent.tick = ev_ff.tick;
               rsp_in.total    = total_ff;
               rsp_in.info     = info_ff;
               rsp_in.warn     = warn_ff;
               rsp_in.err      = err_ff;
            end else begin
               rsp_in.kind = ferl_pkg::KIND_EMPTY;
            end
         end
         default: ;
      endcase
   end

   // control state and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wp_ff        <= '0;
         valid_cnt_ff <= '0;
         info_ff      <= '0;
         warn_ff      <= '0;
         err_ff       <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  case (req_chan.mode)
                     ferl_pkg::MODE_RECORD: begin
                        if (sev_ok) begin
                           wp_ff <= wp_next;
                           if (!full) begin
                              valid_cnt_ff <= valid_cnt_ff + 1'b1;
                           end
                        end
                     end
                     ferl_pkg::MODE_CLEAR: begin
                        wp_ff        <= '0;
                        valid_cnt_ff <= '0;
                        info_ff      <= '0;
                        warn_ff      <= '0;
                        err_ff       <= '0;
                        total_ff     <= '0;
                     end
                     default: ;
                  endcase
               end
            end
            S_SEV: begin
               case (ev_ff.sev)
                  ferl_pkg::SEV_INFO:  info_ff <= inc_res;
                  ferl_pkg::SEV_WARN:  warn_ff <= inc_res;
                  ferl_pkg::SEV_ERROR: err_ff  <= inc_res;
                  default: ;
               endcase
            end
            S_TOT: begin
               if (out_free) begin
                  total_ff <= inc_res;
               end
            end
            default: ;
         endcase
      end
   end

   // item latch, dump walk and result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff   <= req_chan.mode;
         ev_ff     <= req_entry;
         rd_idx_ff <= full ? wp_ff : '0;
         pos_ff    <= '0;
      end
      if (load_rsp) begin
         rsp_ff <= rsp_in;
      end
      if ((state_ff == S_DUMP) && out_free) begin
         pos_ff    <= pos_ff + 1'b1;
         rd_idx_ff <= rd_next;
      end
   end

   // ring memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (accept && (req_chan.mode == ferl_pkg::MODE_RECORD) && sev_ok) begin
         ring_mem[wp_ff] <= req_entry;
      end
      if (state_ff == S_RD) begin
         rd_data_ff <= ring_mem[rd_idx_ff];
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.kind         = rsp_ff.kind;
   assign rsp_chan.out_tick_ms  = rsp_ff.ent.tick;
   assign rsp_chan.out_severity = rsp_ff.ent.sev;
   assign rsp_chan.out_source   = rsp_ff.ent.src;
   assign rsp_chan.out_detail   = rsp_ff.ent.det;
   assign rsp_chan.out_payload  = rsp_ff.ent.pay;
   assign rsp_chan.position     = rsp_ff.pos;
   assign rsp_chan.total_count  = rsp_ff.total;
   assign rsp_chan.info_count   = rsp_ff.info;
   assign rsp_chan.warn_count   = rsp_ff.warn;
   assign rsp_chan.error_count  = rsp_ff.err;
   assign rsp_chan.last         = rsp_ff.last;

`ifndef NO_ASSERTIONS
   // until the ring fills, the write pointer tracks the fill count
   a_wp_tracks_fill: assert property (@(posedge clock) disable iff (reset)
      (valid_cnt_ff != CNT_W'(LOG_DEPTH)) |-> (CNT_W'(wp_ff) == valid_cnt_ff))
      else $error("write pointer out of step with fill count");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      valid_cnt_ff <= CNT_W'(LOG_DEPTH))
      else $error("fill count beyond ring depth");

   // a dump never reads past the stored entries
   a_dump_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RD) |-> ((CNT_W'(pos_ff) < valid_cnt_ff) &&
                              (rd_idx_ff < PTR_W'(LOG_DEPTH - 1) ||
                               rd_idx_ff == PTR_W'(LOG_DEPTH - 1))))
      else $error("dump read outside stored entries");

   a_total_step: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_TOT) && out_free) |=> (total_ff == $past(total_ff) + COUNT_W'(1)))
      else $error("event total not incremented on record");
`endif

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// testbench: self-checking bench for fault_event_ring_logger_unit, random idling both sides
// depends on ferl_pkg, the channel interfaces in ferl_if.sv and the logger top level

module testbench;
   import ferl_pkg::*;

   localparam int unsigned SEV_LEVELS     = 4;
   localparam logic [SEV_W-1:0] SEV_CRIT  = 3'd3;
   localparam int unsigned ITEM_TARGET    = 170;
   localparam int unsigned TAIL_ITEMS     = 25;
   localparam int unsigned HOLD_AFTER     = 60;
   localparam int unsigned HOLD_CYCLES    = 120;
   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned DRAIN_CYCLES   = 40;
   localparam int unsigned PRINT_LIMIT    = 100;

   typedef struct {
      logic [MODE_W-1:0] mode;
      logic [TICK_W-1:0] tick;
      logic [SEV_W-1:0]  sev;
      logic [BYTE_W-1:0] src;
      logic [BYTE_W-1:0] det;
      logic [BYTE_W-1:0] pay;
   } fault_req_t;

   typedef struct {
      logic [KIND_W-1:0]  kind;
      logic [TICK_W-1:0]  tick;
      logic [OSEV_W-1:0]  sev;
      logic [BYTE_W-1:0]  src;
      logic [BYTE_W-1:0]  det;
      logic [BYTE_W-1:0]  pay;
      logic [POS_W-1:0]   pos;
      logic [COUNT_W-1:0] total;
      logic [COUNT_W-1:0] info;
      logic [COUNT_W-1:0] warn;
      logic [COUNT_W-1:0] err;
      logic               last;
   } fault_rsp_t;

   logic clock;
   logic reset;

   ferl_req_if req_chan ();
   ferl_rsp_if rsp_chan ();

   fault_event_ring_logger_unit i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // stimulus and expected results
   fault_req_t queued_requests[$];
   fault_rsp_t awaited_results[$];

   // logger state as predicted
   log_entry_type      ring_copy [LOG_DEPTH] = '{default: '0};
   int unsigned        next_slot    = 0;
   int unsigned        stored_count = 0;
   logic [COUNT_W-1:0] sev_tally [SEV_LEVELS] = '{default: '0};
   logic [COUNT_W-1:0] event_tally = '0;

   // bookkeeping
   int unsigned work_items      = 0;
   int unsigned items_accepted  = 0;
   int unsigned results_checked = 0;
   int unsigned failures        = 0;
   int unsigned n_records = 0, n_rejected = 0, n_dumps = 0, n_full_dumps = 0;
   int unsigned n_summaries = 0, n_clears = 0;

   // handshake helpers
   logic        req_taken   = 1'b0;
   logic        tail_phase  = 1'b0;
   int unsigned send_gap    = 0;
   int unsigned stall_left  = 0;
   int unsigned hold_left   = 0;
   logic        hold_done   = 1'b0;
   int unsigned idle_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   task automatic note_failure(input string msg);
      if (failures < PRINT_LIMIT)
         $display("[%0t] mismatch: %s", $time, msg);
      failures++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         note_failure($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                results_checked, name, got, want));
   endtask

   function automatic fault_rsp_t blank_result();
      fault_rsp_t r;
      r.kind  = KIND_ECHO;
      r.tick  = '0;
      r.sev   = '0;
      r.src   = '0;
      r.det   = '0;
      r.pay   = '0;
      r.pos   = '0;
      r.total = '0;
      r.info  = '0;
      r.warn  = '0;
      r.err   = '0;
      r.last  = 1'b0;
      return r;
   endfunction

   function automatic void wipe_log();
      for (int i = 0; i < LOG_DEPTH; i++)
         ring_copy[i] = '0;
      for (int i = 0; i < SEV_LEVELS; i++)
         sev_tally[i] = '0;
      next_slot    = 0;
      stored_count = 0;
      event_tally  = '0;
   endfunction

   // works out the results of one accepted item and updates the predicted state
   function automatic void predict_logger_results(input fault_req_t rq);
      fault_rsp_t  r;
      int unsigned idx;
      r = blank_result();
      case (rq.mode)
         MODE_RECORD: begin
            if (rq.sev >= SEV_LEVELS) begin
               n_rejected++;
            end else begin
               ring_copy[next_slot] = '{tick: rq.tick, sev: rq.sev[OSEV_W-1:0],
                                        src: rq.src, det: rq.det, pay: rq.pay};
               next_slot = (next_slot == LOG_DEPTH - 1) ? 0 : next_slot + 1;
               if (stored_count < LOG_DEPTH)
                  stored_count++;
               sev_tally[rq.sev[OSEV_W-1:0]] += 1;
               event_tally += 1;
               r.kind = KIND_ECHO;
               r.tick = rq.tick;
               r.sev  = rq.sev[OSEV_W-1:0];
               r.src  = rq.src;
               r.det  = rq.det;
               r.pay  = rq.pay;
               r.last = 1'b1;
               awaited_results.push_back(r);
               n_records++;
            end
         end
         MODE_CLEAR: begin
            wipe_log();
            n_clears++;
         end
         MODE_DUMP: begin
            n_dumps++;
            if (stored_count == 0) begin
               r.kind = KIND_EMPTY;
               r.last = 1'b1;
               awaited_results.push_back(r);
            end else begin
               if (stored_count == LOG_DEPTH)
                  n_full_dumps++;
               // a full ring starts at the oldest entry, which sits at the write slot
               idx = (stored_count < LOG_DEPTH) ? 0 : next_slot;
               for (int unsigned i = 0; i < stored_count; i++) begin
                  r      = blank_result();
                  r.kind = KIND_ENTRY;
                  r.tick = ring_copy[idx].tick;
                  r.sev  = ring_copy[idx].sev;
                  r.src  = ring_copy[idx].src;
                  r.det  = ring_copy[idx].det;
                  r.pay  = ring_copy[idx].pay;
                  r.pos  = i[POS_W-1:0];
                  r.last = (i + 1 == stored_count);
                  awaited_results.push_back(r);
                  idx = (idx == LOG_DEPTH - 1) ? 0 : idx + 1;
               end
            end
         end
         default: begin
            r.kind  = KIND_SUMMARY;
            r.tick  = rq.tick;
            r.total = event_tally;
            r.info  = sev_tally[SEV_INFO];
            r.warn  = sev_tally[SEV_WARN];
            r.err   = sev_tally[SEV_ERROR];
            r.last  = 1'b1;
            awaited_results.push_back(r);
            n_summaries++;
         end
      endcase
   endfunction

   task automatic queue_request(input logic [MODE_W-1:0] mode, input logic [TICK_W-1:0] tick,
                                input logic [SEV_W-1:0] sev, input logic [BYTE_W-1:0] src,
                                input logic [BYTE_W-1:0] det, input logic [BYTE_W-1:0] pay);
      queued_requests.push_back('{mode: mode, tick: tick, sev: sev, src: src, det: det,
                                  pay: pay});
      // rejected records leave the log and counters untouched and do not count
      if (!(mode == MODE_RECORD && sev >= SEV_LEVELS))
         work_items++;
   endtask

   // one item of the given mode with random fields
   task automatic queue_random_op(input logic [MODE_W-1:0] mode);
      logic [31:0] rnd;
      rnd = $urandom;
      queue_request(mode, $urandom, rnd[SEV_W-1:0], rnd[15:8], rnd[23:16], rnd[31:24]);
   endtask

   // sender: presents queued items at the falling edge
   always @(negedge clock) begin
      fault_req_t nxt;
      logic       drive_valid;
      if (reset) begin
         req_chan.valid <= 1'b0;
         send_gap       <= 0;
      end else begin
         drive_valid = req_chan.valid && !req_taken;
         if (!drive_valid) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
            end else if (queued_requests.size() > 0) begin
               if (queued_requests.size() > TAIL_ITEMS && $urandom_range(0, 5) == 0) begin
                  send_gap <= $urandom_range(0, 8);
               end else begin
                  nxt                 = queued_requests.pop_front();
                  drive_valid         = 1'b1;
                  req_chan.mode      <= nxt.mode;
                  req_chan.tick_ms   <= nxt.tick;
                  req_chan.severity  <= nxt.sev;
                  req_chan.source_id <= nxt.src;
                  req_chan.detail    <= nxt.det;
                  req_chan.payload   <= nxt.pay;
               end
            end
         end
         req_chan.valid <= drive_valid;
         if (queued_requests.size() <= TAIL_ITEMS)
            tail_phase <= 1'b1;
      end
   end

   // receiver: random stalls, one long hold-off so the block backs up into its input
   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_chan.ready <= 1'b0;
         hold_left      <= hold_left - 1;
      end else if (!hold_done && items_accepted >= HOLD_AFTER) begin
         rsp_chan.ready <= 1'b0;
         hold_left      <= HOLD_CYCLES - 1;
         hold_done      <= 1'b1;
      end else if (tail_phase) begin
         rsp_chan.ready <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left     <= stall_left - 1;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left     <= $urandom_range(0, 8);
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // monitor: predicts on each accepted item, checks each accepted result
   always @(posedge clock) begin
      fault_req_t got_req;
      fault_rsp_t want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_chan.valid && req_chan.ready;
         if (req_chan.valid && req_chan.ready) begin
            got_req.mode = req_chan.mode;
            got_req.tick = req_chan.tick_ms;
            got_req.sev  = req_chan.severity;
            got_req.src  = req_chan.source_id;
            got_req.det  = req_chan.detail;
            got_req.pay  = req_chan.payload;
            predict_logger_results(got_req);
            items_accepted++;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (awaited_results.size() == 0) begin
               note_failure($sformatf("result %0d arrived with nothing expected, kind %0d",
                                      results_checked, rsp_chan.kind));
            end else begin
               want = awaited_results.pop_front();
               check_field("kind",         rsp_chan.kind,         want.kind);
               check_field("out_tick_ms",  rsp_chan.out_tick_ms,  want.tick);
               check_field("out_severity", rsp_chan.out_severity, want.sev);
               check_field("out_source",   rsp_chan.out_source,   want.src);
               check_field("out_detail",   rsp_chan.out_detail,   want.det);
               check_field("out_payload",  rsp_chan.out_payload,  want.pay);
               check_field("position",     rsp_chan.position,     want.pos);
               check_field("total_count",  rsp_chan.total_count,  want.total);
               check_field("info_count",   rsp_chan.info_count,   want.info);
               check_field("warn_count",   rsp_chan.warn_count,   want.warn);
               check_field("error_count",  rsp_chan.error_count,  want.err);
               check_field("last",         rsp_chan.last,         want.last);
            end
            results_checked++;
         end
      end
   end

   // watchdog on cycles with no handshake on either side
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout after %0d cycles without progress, %0d results outstanding",
                  idle_cycles, awaited_results.size());
         $display("** fault_event_ring_logger_unit: FAILED **");
         $finish;
      end
   end

   initial begin
      int unsigned      burst;
      int unsigned      pick;
      logic [SEV_W-1:0] sev;
      logic [31:0]      rnd;

      reset = 1'b1;

      // directed: empty log, field extremes, every severity, rejects, clear
      queue_request(MODE_DUMP,    '0,            '0,       '0,    '0,    '0);
      queue_request(MODE_SUMMARY, '1,            '1,       '1,    '1,    '1);
      queue_request(MODE_CLEAR,   '0,            '0,       '0,    '0,    '0);
      queue_request(MODE_RECORD,  '0,            SEV_W'(SEV_INFO), '0, '0, '0);
      queue_request(MODE_RECORD,  '1,            SEV_CRIT, '1,    '1,    '1);
      queue_request(MODE_RECORD,  32'h5555_aaaa, SEV_W'(SEV_WARN), 8'ha5, 8'h5a, 8'h3c);
      queue_request(MODE_RECORD,  32'haaaa_5555, SEV_W'(SEV_ERROR), 8'h5a, 8'ha5, 8'hc3);
      queue_request(MODE_RECORD,  32'h1234_5678, 3'd4,     8'h11, 8'h22, 8'h33);
      queue_request(MODE_RECORD,  '1,            3'd7,     '1,    '1,    '1);
      queue_request(MODE_DUMP,    '1,            '1,       '1,    '1,    '1);
      queue_request(MODE_SUMMARY, '0,            '0,       '0,    '0,    '0);
      queue_request(MODE_CLEAR,   '1,            '1,       '1,    '1,    '1);
      queue_request(MODE_DUMP,    '0,            '0,       '0,    '0,    '0);
      queue_request(MODE_SUMMARY, 32'h8000_0001, '0,       '0,    '0,    '0);
      queue_request(MODE_RECORD,  32'h0000_ffff, SEV_W'(SEV_INFO), 8'h80, 8'h01, 8'hfe);
      queue_request(MODE_DUMP,    '0,            '0,       '0,    '0,    '0);
      queue_request(MODE_SUMMARY, 32'hffff_0000, '1,       '1,    '1,    '1);

      // random rounds: a burst of records, then a readout (now and then after a clear) or noise
      while (work_items < ITEM_TARGET) begin
         burst = ($urandom_range(0, 3) == 0) ? $urandom_range(14, 24) : $urandom_range(1, 8);
         repeat (burst) begin
            sev = ($urandom_range(0, 11) == 0) ? SEV_W'($urandom_range(4, 7))
                                                : SEV_W'($urandom_range(0, 3));
            rnd = $urandom;
            queue_request(MODE_RECORD, $urandom, sev, rnd[7:0], rnd[15:8], rnd[23:16]);
         end
         pick = $urandom_range(0, 9);
         if (pick < 6) begin
            queue_random_op(MODE_DUMP);
            if ($urandom_range(0, 1) == 0)
               queue_random_op(MODE_SUMMARY);
         end else if (pick < 8) begin
            queue_random_op(MODE_SUMMARY);
            queue_random_op(MODE_DUMP);
         end else if (pick == 8) begin
            queue_random_op(MODE_CLEAR);
            if ($urandom_range(0, 1) == 0)
               queue_random_op(MODE_DUMP);
            else
               queue_random_op(MODE_SUMMARY);
         end else begin
            repeat ($urandom_range(1, 3))
               queue_random_op(MODE_W'($urandom_range(0, 3)));
         end
      end

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (queued_requests.size() != 0 || req_chan.valid)
         @(posedge clock);
      while (awaited_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d items: %0d records, %0d rejected, %0d dumps (%0d of a full ring),",
               items_accepted, n_records, n_rejected, n_dumps, n_full_dumps);
      $display("%0d summaries, %0d clears; %0d results checked, %0d mismatches",
               n_summaries, n_clears, results_checked, failures);
      if (failures == 0)
         $display("** fault_event_ring_logger_unit: PASSED **");
      else
         $display("** fault_event_ring_logger_unit: FAILED **");
      $finish;
   end

endmodule

@@ fault_event_ring_logger_unit.f @@
rtl/core/ferl_pkg.sv
rtl/core/ferl_if.sv
rtl/core/fault_event_ring_logger_unit.sv
dv/testbench.sv
